>>> hdl/tlgs_pkg.sv
// Package: types, codes and helpers shared by the Life grid stepper.
package tlgs_pkg;

	localparam int MAX_ROWS      = 64;
	localparam int MAX_COLS      = 64;
	localparam int ROW_W         = 64;
	localparam int SIZE_W        = 7;
	localparam int IDX_W         = 6;
	localparam int GEN_W         = 16;
	localparam int GRID_MIN      = 3;
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] row_index;
		logic [ROW_W-1:0] row_cells;
		logic [GEN_W-1:0] generations;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_row_index;
		logic [ROW_W-1:0] out_row_cells;
		logic             all_dead;
		logic             last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_GEN,
		ST_EMIT
	} phase_t;

	typedef struct packed {
		logic             shift;
		phase_t           phase;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] step;
		logic             dead;
	} ctrl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
	                                                  input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(GRID_MIN))
			r = SIZE_W'(GRID_MIN);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] col_mask(input logic [SIZE_W-1:0] cols);
		logic [ROW_W-1:0] m;
		if (cols >= SIZE_W'(ROW_W))
			m = '1;
		else
			m = (ROW_W'(1) << cols) - ROW_W'(1);
		return m;
	endfunction

endpackage

>>> hdl/tlgs_row_cell.sv
// One row of the grid: loads from the port or takes its neighbour's row on a shift.
module tlgs_row_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load_en,
	input  logic [tlgs_pkg::ROW_W-1:0] load_row,
	input  logic                     shift_en,
	input  logic [tlgs_pkg::ROW_W-1:0] shift_row,
	output logic [tlgs_pkg::ROW_W-1:0] row_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (load_en) begin
			row_q <= load_row;
		end else if (shift_en) begin
			row_q <= shift_row;
		end
	end

endmodule

>>> hdl/tlgs_rule.sv
// B3/S23 update of one row from its wrapped upper, own and lower rows.
module tlgs_rule (
	input  logic [tlgs_pkg::ROW_W-1:0]  up,
	input  logic [tlgs_pkg::ROW_W-1:0]  cur,
	input  logic [tlgs_pkg::ROW_W-1:0]  dn,
	input  logic [tlgs_pkg::SIZE_W-1:0] cols,
	input  logic [tlgs_pkg::ROW_W-1:0]  mask,
	output logic [tlgs_pkg::ROW_W-1:0]  nxt
);

	logic [tlgs_pkg::IDX_W-1:0] top_col;
	logic [tlgs_pkg::ROW_W-1:0] up_w, up_e, cur_w, cur_e, dn_w, dn_e;

	function automatic logic [tlgs_pkg::ROW_W-1:0] from_west(
		input logic [tlgs_pkg::ROW_W-1:0] r, input logic [tlgs_pkg::IDX_W-1:0] tc,
		input logic [tlgs_pkg::ROW_W-1:0] m);
		logic [tlgs_pkg::ROW_W-1:0] w;
		w    = {r[tlgs_pkg::ROW_W-2:0], 1'b0};
		w[0] = r[tc];
		return w & m;
	endfunction

	function automatic logic [tlgs_pkg::ROW_W-1:0] from_east(
		input logic [tlgs_pkg::ROW_W-1:0] r, input logic [tlgs_pkg::IDX_W-1:0] tc,
		input logic [tlgs_pkg::ROW_W-1:0] m);
		logic [tlgs_pkg::ROW_W-1:0] e;
		e     = {1'b0, r[tlgs_pkg::ROW_W-1:1]};
		e[tc] = e[tc] | r[0];
		return e & m;
	endfunction

	assign top_col = tlgs_pkg::IDX_W'(cols - tlgs_pkg::SIZE_W'(1));
	assign up_w    = from_west(up, top_col, mask);
	assign up_e    = from_east(up, top_col, mask);
	assign cur_w   = from_west(cur, top_col, mask);
	assign cur_e   = from_east(cur, top_col, mask);
	assign dn_w    = from_west(dn, top_col, mask);
	assign dn_e    = from_east(dn, top_col, mask);

	always_comb begin
		logic [3:0] sum;
		nxt = '0;
		for (int j = 0; j < tlgs_pkg::ROW_W; j++) begin
			sum = 4'(up_w[j]) + 4'(up[j]) + 4'(up_e[j]) + 4'(cur_w[j]) + 4'(cur_e[j])
			    + 4'(dn_w[j]) + 4'(dn[j]) + 4'(dn_e[j]);
			nxt[j] = mask[j] & ((sum == 4'(tlgs_pkg::BIRTH_COUNT))
			       | (cur[j] & (sum == 4'(tlgs_pkg::SURVIVE_COUNT))));
		end
	end

endmodule

>>> hdl/tlgs_ctrl.sv
// Sequencer: priming pass, generation passes with early stop, emission pass.
module tlgs_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        run_start,
	input  logic [tlgs_pkg::GEN_W-1:0]  generations,
	input  logic [tlgs_pkg::SIZE_W-1:0] rows_n,
	input  logic                        feed_live,
	output tlgs_pkg::ctrl_t             ctrl,
	output logic                        busy
);

	tlgs_pkg::phase_t           state_q, state_d;
	logic [tlgs_pkg::IDX_W-1:0] step_q;
	logic [tlgs_pkg::GEN_W-1:0] gens_q;
	logic                       acc_q;
	logic                       dead_q;
	logic                       step_last;
	logic                       pass_end;
	logic                       pass_live;

	assign step_last = step_q == tlgs_pkg::IDX_W'(rows_n - tlgs_pkg::SIZE_W'(1));
	assign pass_end  = (state_q != tlgs_pkg::ST_IDLE) && step_last;
	assign pass_live = acc_q | feed_live;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlgs_pkg::ST_IDLE: begin
				if (run_start) state_d = tlgs_pkg::ST_PRIME;
			end
			tlgs_pkg::ST_PRIME: begin
				if (pass_end) begin
					if (gens_q == '0 || !pass_live) state_d = tlgs_pkg::ST_EMIT;
					else state_d = tlgs_pkg::ST_GEN;
				end
			end
			tlgs_pkg::ST_GEN: begin
				if (pass_end) begin
					if (gens_q == tlgs_pkg::GEN_W'(1) || !pass_live)
						state_d = tlgs_pkg::ST_EMIT;
				end
			end
			tlgs_pkg::ST_EMIT: begin
				if (pass_end) state_d = tlgs_pkg::ST_IDLE;
			end
			default: state_d = tlgs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlgs_pkg::ST_IDLE;
			step_q  <= '0;
			gens_q  <= '0;
			acc_q   <= 1'b0;
			dead_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == tlgs_pkg::ST_IDLE || pass_end) begin
				step_q <= '0;
				acc_q  <= 1'b0;
			end else begin
				step_q <= step_q + tlgs_pkg::IDX_W'(1);
				acc_q  <= pass_live;
			end
			if (run_start) begin
				gens_q <= generations;
			end else if (state_q == tlgs_pkg::ST_GEN && pass_end) begin
				gens_q <= gens_q - tlgs_pkg::GEN_W'(1);
			end
			if (pass_end && (state_q inside {tlgs_pkg::ST_PRIME, tlgs_pkg::ST_GEN})) begin
				dead_q <= !pass_live;
			end
		end
	end

	assign busy       = state_q != tlgs_pkg::ST_IDLE;
	assign ctrl.shift = busy;
	assign ctrl.phase = state_q;
	assign ctrl.first = step_q == '0;
	assign ctrl.last  = step_last;
	assign ctrl.step  = step_q;
	assign ctrl.dead  = dead_q;

endmodule

>>> hdl/toroidal_life_grid_stepper.sv
// Top level: ring of row cells, shared rule unit, sequencer and result register.
// A load item leaves busy low. A run item keeps busy high through one pass
// that masks the rows, one pass per generation actually computed (the requested
// count, cut short once the grid is dead) and one emission pass. Each pass
// rotates the ring of row cells by one row per cycle through a single rule
// unit. Results appear one row per cycle, row 0 first, each marked by
// result_strobe for one cycle and registered in the cycle after the ring shows
// it; the receiver must take them as they come. No clearing pass follows reset.
module toroidal_life_grid_stepper (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tlgs_pkg::in_item_t          item,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tlgs_pkg::SIZE_W-1:0] cfg_data,
	output logic                        result_strobe,
	output tlgs_pkg::out_item_t         result
);

	logic [tlgs_pkg::SIZE_W-1:0] grid_rows_q, grid_cols_q;
	logic [tlgs_pkg::SIZE_W-1:0] rows_n, cols_n;
	logic [tlgs_pkg::ROW_W-1:0]  mask;
	logic [tlgs_pkg::ROW_W-1:0]  cells [tlgs_pkg::MAX_ROWS];
	logic [tlgs_pkg::ROW_W-1:0]  head, feed, rule_row, dn_row;
	logic [tlgs_pkg::ROW_W-1:0]  up_q, row0_q;
	logic                        accept, load_acc, run_start;
	tlgs_pkg::ctrl_t             ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= tlgs_pkg::SIZE_W'(tlgs_pkg::MAX_ROWS);
			grid_cols_q <= tlgs_pkg::SIZE_W'(tlgs_pkg::MAX_COLS);
		end else if (cfg_we) begin
			if (cfg_index == tlgs_pkg::CFG_ROWS) grid_rows_q <= cfg_data;
			if (cfg_index == tlgs_pkg::CFG_COLS) grid_cols_q <= cfg_data;
		end
	end

	assign rows_n = tlgs_pkg::clamp_size(grid_rows_q, tlgs_pkg::SIZE_W'(tlgs_pkg::MAX_ROWS));
	assign cols_n = tlgs_pkg::clamp_size(grid_cols_q, tlgs_pkg::SIZE_W'(tlgs_pkg::MAX_COLS));
	assign mask   = tlgs_pkg::col_mask(cols_n);

	assign accept    = start && !busy;
	assign load_acc  = accept && item.cmd == tlgs_pkg::CMD_LOAD
	                && {1'b0, item.row_index} < rows_n;
	assign run_start = accept && item.cmd == tlgs_pkg::CMD_RUN;

	tlgs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_start  (run_start),
		.generations(item.generations),
		.rows_n     (rows_n),
		.feed_live  (|feed),
		.ctrl       (ctrl),
		.busy       (busy)
	);

	assign head   = cells[0];
	assign dn_row = ctrl.last ? row0_q : cells[1];

	tlgs_rule u_rule (
		.up  (up_q),
		.cur (head),
		.dn  (dn_row),
		.cols(cols_n),
		.mask(mask),
		.nxt (rule_row)
	);

	always_comb begin
		case (ctrl.phase)
			tlgs_pkg::ST_PRIME: feed = head & mask;
			tlgs_pkg::ST_GEN:   feed = rule_row;
			default:            feed = head;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			up_q <= ctrl.last ? feed : head;
			if (ctrl.first) row0_q <= head;
		end
	end

	for (genvar k = 0; k < tlgs_pkg::MAX_ROWS; k++) begin : g_row
		logic [tlgs_pkg::ROW_W-1:0] shift_row;
		if (k < tlgs_pkg::MAX_ROWS - 1) begin : g_mid
			assign shift_row = (tlgs_pkg::SIZE_W'(k + 1) == rows_n) ? feed : cells[k + 1];
		end else begin : g_end
			assign shift_row = feed;
		end
		tlgs_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_acc && item.row_index == tlgs_pkg::IDX_W'(k)),
			.load_row (item.row_cells & mask),
			.shift_en (ctrl.shift && tlgs_pkg::SIZE_W'(k) < rows_n),
			.shift_row(shift_row),
			.row_q    (cells[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= ctrl.phase == tlgs_pkg::ST_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		result.out_row_index <= ctrl.step;
		result.out_row_cells <= head;
		result.all_dead      <= ctrl.dead;
		result.last          <= ctrl.last;
	end

	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(ctrl.phase == tlgs_pkg::ST_EMIT))
		else $error("result strobe outside emission");

	a_emit_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |=> result_strobe)
		else $error("emission broken before last row");

	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("item after last row");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && $past(result_strobe) && !$past(result.last) |->
		result.out_row_index == $past(result.out_row_index) + tlgs_pkg::IDX_W'(1))
		else $error("row index not consecutive");

	a_dead_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && $past(result_strobe) && !$past(result.last) |->
		result.all_dead == $past(result.all_dead))
		else $error("all_dead changed within a run");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the toroidal Life grid stepper: loads, runs and grid sizes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tlgs_pkg::*;

	typedef struct {
		in_item_t    item;
		int unsigned gap;
	} queued_cmd_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	in_item_t            item      = '0;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = CFG_ROWS;
	logic [SIZE_W-1:0]   cfg_data  = '0;
	logic                busy;
	logic                result_strobe;
	out_item_t           result;

	queued_cmd_t         cmd_backlog[$];
	queued_cmd_t         head;
	out_item_t           row_forecast[$];
	out_item_t           due;
	logic [ROW_W-1:0]    life_cells [MAX_ROWS] = '{default: '0};
	logic [SIZE_W-1:0]   rows_cfg = SIZE_W'(64);
	logic [SIZE_W-1:0]   cols_cfg = SIZE_W'(64);
	int unsigned         hold_cycles = 0;
	int                  counted = 0;
	bit                  failed = 1'b0;

	toroidal_life_grid_stepper i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result        (result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
		if (v < 3)
			return 3;
		if (v > 64)
			return 64;
		return v;
	endfunction

	function automatic logic [ROW_W-1:0] width_mask(input int unsigned n);
		if (n >= ROW_W)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned k;
		k = $urandom_range(0, 19);
		if (quiet || k <= 10)
			return 0;
		if (k <= 17)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return SIZE_W'($urandom_range(3, 12));
			5, 6: return SIZE_W'($urandom_range(13, 64));
			7: begin
				case ($urandom_range(0, 6))
					0: return SIZE_W'(0);
					1: return SIZE_W'(1);
					2: return SIZE_W'(2);
					3: return SIZE_W'(3);
					4: return SIZE_W'(64);
					5: return SIZE_W'(65);
					default: return SIZE_W'(127);
				endcase
			end
			default: return SIZE_W'($urandom_range(0, 127));
		endcase
	endfunction

	// Advances the local grid copy and queues the rows the block should emit.
	task automatic advance_life(input in_item_t it);
		int unsigned       n_rows, n_cols, cnt, g, r, c, dr, dc;
		logic [ROW_W-1:0]  mask, any, next_row;
		logic [ROW_W-1:0]  prev [MAX_ROWS];
		out_item_t         res;
		n_rows = eff_size(rows_cfg);
		n_cols = eff_size(cols_cfg);
		mask = width_mask(n_cols);
		if (it.cmd == CMD_LOAD) begin
			if (it.row_index < n_rows)
				life_cells[it.row_index] = it.row_cells & mask;
		end else begin
			for (g = 0; g < it.generations; g++) begin
				for (r = 0; r < n_rows; r++)
					prev[r] = life_cells[r] & mask;
				any = '0;
				for (r = 0; r < n_rows; r++) begin
					next_row = '0;
					for (c = 0; c < n_cols; c++) begin
						cnt = 0;
						for (dr = 0; dr < 3; dr++)
							for (dc = 0; dc < 3; dc++)
								if (!(dr == 1 && dc == 1))
									cnt += prev[(r + n_rows + dr - 1) % n_rows]
									           [(c + n_cols + dc - 1) % n_cols];
						next_row[c] = (cnt == BIRTH_COUNT) ||
						              (prev[r][c] && cnt == SURVIVE_COUNT);
					end
					life_cells[r] = next_row;
					any |= next_row;
				end
				if (any == '0)
					break;
			end
			any = '0;
			for (r = 0; r < n_rows; r++) begin
				life_cells[r] &= mask;
				any |= life_cells[r];
			end
			for (r = 0; r < n_rows; r++) begin
				res.out_row_index = IDX_W'(r);
				res.out_row_cells = life_cells[r];
				res.all_dead      = (any == '0);
				res.last          = (r + 1 == n_rows);
				row_forecast.insert(row_forecast.size(), res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			hold_cycles <= 0;
		end else begin
			if (start && !busy)
				advance_life(item);
			if (start && busy) begin
				// item held until taken
			end else if (cmd_backlog.size() != 0 && hold_cycles >= cmd_backlog[0].gap) begin
				head = cmd_backlog.pop_front();
				item <= head.item;
				start <= 1'b1;
				hold_cycles <= 0;
			end else begin
				start <= 1'b0;
				if (cmd_backlog.size() != 0)
					hold_cycles <= hold_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (row_forecast.size() == 0) begin
				$error("unexpected row: out_row_index %0d", result.out_row_index);
				failed = 1'b1;
			end else begin
				due = row_forecast.pop_front();
				if (result.out_row_index !== due.out_row_index) begin
					$error("out_row_index: expected %0d, got %0d",
					       due.out_row_index, result.out_row_index);
					failed = 1'b1;
				end
				if (result.out_row_cells !== due.out_row_cells) begin
					$error("out_row_cells: expected %h, got %h",
					       due.out_row_cells, result.out_row_cells);
					failed = 1'b1;
				end
				if (result.all_dead !== due.all_dead) begin
					$error("all_dead: expected %0b, got %0b", due.all_dead, result.all_dead);
					failed = 1'b1;
				end
				if (result.last !== due.last) begin
					$error("last: expected %0b, got %0b", due.last, result.last);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic add_item(input logic c, input logic [IDX_W-1:0] idx,
	                        input logic [ROW_W-1:0] cells, input logic [GEN_W-1:0] gens,
	                        input bit quiet);
		queued_cmd_t q;
		q.item.cmd         = c;
		q.item.row_index   = idx;
		q.item.row_cells   = cells;
		q.item.generations = gens;
		q.gap              = pick_gap(quiet);
		cmd_backlog.insert(cmd_backlog.size(), q);
		counted++;
	endtask

	task automatic wait_idle(input int unsigned settle);
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || start || busy || row_forecast.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c);
		wait_idle(8);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_cfg = r;
		cols_cfg = c;
		@(negedge clk);
	endtask

	// One load burst and its run, or a grid that dies at once under a long run.
	task automatic queue_episode();
		bit                quiet;
		int unsigned       n_rows, n_cols, kind, n_loads, i, live_row;
		logic [ROW_W-1:0]  mask, row_bits;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  gens;
		quiet = ($urandom_range(0, 3) == 0);
		n_rows = eff_size(rows_cfg);
		n_cols = eff_size(cols_cfg);
		mask = width_mask(n_cols);
		kind = $urandom_range(0, 9);
		if (kind == 0 && n_rows <= 24) begin
			live_row = $urandom_range(0, n_rows - 1);
			for (i = 0; i < n_rows; i++) begin
				row_bits = rand64() & ~mask;
				if (i == live_row)
					row_bits |= 64'd1 << $urandom_range(0, n_cols - 1);
				add_item(CMD_LOAD, IDX_W'(i), row_bits, GEN_W'($urandom), quiet);
			end
			add_item(CMD_RUN, IDX_W'($urandom), rand64(), GEN_W'($urandom_range(0, 65535)), quiet);
		end else begin
			n_loads = (kind == 1) ? 0 : $urandom_range(1, 8);
			for (i = 0; i < n_loads; i++) begin
				if (n_rows < 64 && $urandom_range(0, 9) == 0) begin
					idx = IDX_W'($urandom_range(n_rows, 63));
				end else begin
					idx = IDX_W'($urandom_range(0, n_rows - 1));
				end
				case ($urandom_range(0, 4))
					0: row_bits = rand64() & rand64();
					1: row_bits = rand64() | rand64();
					2: row_bits = '1;
					default: row_bits = rand64();
				endcase
				add_item(CMD_LOAD, idx, row_bits, GEN_W'($urandom), quiet);
			end
			gens = (n_rows <= 12) ? GEN_W'($urandom_range(0, 20)) : GEN_W'($urandom_range(0, 6));
			add_item(CMD_RUN, IDX_W'($urandom), rand64(), gens, quiet);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty grid at full size, then long run that stops once dead
		add_item(CMD_RUN, 6'h3F, '1, 16'h0000, 1'b0);
		add_item(CMD_RUN, 6'h00, '0, 16'hFFFF, 1'b0);
		add_item(CMD_LOAD, 6'd0, '1, 16'hFFFF, 1'b0);
		add_item(CMD_LOAD, 6'd63, 64'h5555_5555_5555_5555, 16'h0000, 1'b0);
		add_item(CMD_LOAD, 6'd1, 64'h8000_0000_0000_0001, 16'h1234, 1'b0);
		add_item(CMD_RUN, 6'd0, '0, 16'd1, 1'b0);
		add_item(CMD_RUN, 6'd0, '0, 16'd2, 1'b0);

		// sizes below the minimum, out-of-range rows, bits above the width
		write_size(SIZE_W'(2), SIZE_W'(0));
		add_item(CMD_LOAD, 6'd5, '1, 16'd0, 1'b1);
		add_item(CMD_LOAD, 6'd63, '1, 16'd0, 1'b1);
		add_item(CMD_LOAD, 6'd0, '1, 16'd0, 1'b1);
		add_item(CMD_LOAD, 6'd1, 64'd0, 16'd0, 1'b1);
		add_item(CMD_LOAD, 6'd2, 64'hF0F0_0000_0000_00F2, 16'd0, 1'b1);
		add_item(CMD_RUN, 6'd0, '0, 16'd1, 1'b1);
		add_item(CMD_RUN, 6'd0, '0, 16'd0, 1'b1);

		// sizes above the maximum: hidden rows come back into use
		write_size(SIZE_W'(127), SIZE_W'(65));
		add_item(CMD_RUN, 6'd0, '0, 16'd0, 1'b0);
		add_item(CMD_RUN, 6'd0, '0, 16'd3, 1'b0);

		write_size(SIZE_W'(64), SIZE_W'(3));
		add_item(CMD_LOAD, 6'd10, 64'hABCD_0000_0000_0002, 16'd0, 1'b0);
		add_item(CMD_RUN, 6'd0, '0, 16'd1, 1'b0);
		add_item(CMD_RUN, 6'd0, '0, 16'd0, 1'b0);

		while (counted < 220) begin
			write_size(pick_size(), pick_size());
			repeat ($urandom_range(2, 5))
				queue_episode();
		end

		wait_idle(200);
		if (!failed && row_forecast.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
